// ===== rtl/core/mcnt_pkg.sv =====
// mcnt_pkg: shared types, codes and constants of the midi channel note tracker
// used by every module of the core; no dependencies
`default_nettype none
package mcnt_pkg;

   localparam int NUM_CHANNELS = 16;
   localparam int NUM_NOTES    = 128;

   localparam int CH_W      = 4;
   localparam int NOTE_W    = 7;
   localparam int CNT_CH_W  = CH_W + 1;
   localparam int MEM_AW    = CH_W + NOTE_W;
   localparam int MEM_DEPTH = NUM_CHANNELS * NUM_NOTES;
   localparam int CNT_W     = MEM_AW;
   localparam int HOLD_W    = 8;
   localparam int BEND_W    = 14;
   localparam int PROD_W    = 2 * NOTE_W;

   localparam int REQ_DATA_W = 24;
   localparam int REQ_USER_W = 1;
   localparam int RSP_DATA_W = 64;
   localparam int RSP_USER_W = 2;
   localparam int CSR_ADDR_W = 1;
   localparam int CSR_DATA_W = 8;

   // register indexes
   localparam logic [CSR_ADDR_W-1:0] CSR_TRANSPOSE = 1'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_EXPR_MAX  = 1'd1;

   // operation codes
   localparam logic [2:0] OP_NOTE_ON   = 3'd0;
   localparam logic [2:0] OP_NOTE_OFF  = 3'd1;
   localparam logic [2:0] OP_CONTROL   = 3'd2;
   localparam logic [2:0] OP_PROGRAM   = 3'd3;
   localparam logic [2:0] OP_BEND      = 3'd4;
   localparam logic [2:0] OP_NOTES_OFF = 3'd5;
   localparam logic [2:0] OP_SOUND_OFF = 3'd6;

   localparam logic [CH_W-1:0]   DRUM_CHANNEL = 4'd9;
   localparam logic [NOTE_W-1:0] CC_VOLUME    = 7'd7;
   localparam logic [NOTE_W-1:0] CC_PAN       = 7'd10;
   localparam logic [NOTE_W-1:0] CC_EXPRESSION = 7'd11;
   localparam logic [NOTE_W-1:0] CC_REVERB    = 7'd91;
   localparam logic [NOTE_W-1:0] CC_CHORUS    = 7'd93;
   localparam logic [NOTE_W-1:0] NOTE_TOP     = 7'd127;
   localparam logic [HOLD_W-1:0] HOLD_MAX     = 8'd255;
   localparam logic [7:0]        NOTE_NONE    = 8'hff;

   typedef struct packed {
      logic accept;
      logic mem_read;
      logic update;
      logic init_wr;
      logic clr_wr;
      logic clr_chan;
      logic scan;
      logic cnt_clear;
      logic cnt_inc;
      logic load_rsp;
   } ctl_cmd_type;

   typedef struct packed {
      logic note_op;
      logic clear_op;
      logic need_scan;
      logic cnt_init_end;
      logic cnt_row_end;
      logic cnt_scan_end;
      logic rsp_free;
   } ctl_sts_type;

endpackage
`default_nettype wire

// ===== rtl/core/mcnt_ctrl.sv =====
// mcnt_ctrl: sequencing state machine of the note tracker
// depends on mcnt_pkg; drives commands into mcnt_datapath
`default_nettype none
module mcnt_ctrl import mcnt_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire ctl_sts_type sts,
   output ctl_cmd_type      cmd
);

   typedef enum logic [6:0] {
      S_INIT   = 7'b0000001,
      S_IDLE   = 7'b0000010,
      S_EXEC   = 7'b0000100,
      S_UPDATE = 7'b0001000,
      S_SCAN   = 7'b0010000,
      S_CLEAR  = 7'b0100000,
      S_RESULT = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         S_INIT: begin
            cmd.init_wr = 1'b1;
            cmd.cnt_inc = 1'b1;
            if (sts.cnt_init_end) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.accept = 1'b1;
               state_in   = S_EXEC;
            end
         end
         S_EXEC: begin
            cmd.cnt_clear = 1'b1;
            if (sts.note_op) begin
               cmd.mem_read = 1'b1;
               state_in     = S_UPDATE;
            end else if (sts.clear_op) begin
               state_in = S_CLEAR;
            end else begin
               state_in = S_RESULT;
            end
         end
         S_UPDATE: begin
            cmd.update    = 1'b1;
            cmd.cnt_clear = 1'b1;
            state_in      = sts.need_scan ? S_SCAN : S_RESULT;
         end
         S_SCAN: begin
            cmd.scan    = 1'b1;
            cmd.cnt_inc = 1'b1;
            if (sts.cnt_scan_end) begin
               state_in = S_RESULT;
            end
         end
         S_CLEAR: begin
            cmd.clr_wr  = 1'b1;
            cmd.cnt_inc = 1'b1;
            if (sts.cnt_row_end) begin
               cmd.clr_chan = 1'b1;
               state_in     = S_RESULT;
            end
         end
         S_RESULT: begin
            if (sts.rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_INIT;
         end
      endcase
   end

endmodule
`default_nettype wire

// ===== rtl/core/mcnt_datapath.sv =====
// mcnt_datapath: item registers, config registers, hold-count memory,
// per-channel summary registers and the result register; depends on mcnt_pkg
`default_nettype none
module mcnt_datapath import mcnt_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   input  wire logic [REQ_USER_W-1:0] req_tuser,
   input  wire logic                  csr_we,
   input  wire logic [CSR_ADDR_W-1:0] csr_addr,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata,
   input  wire ctl_cmd_type           cmd,
   output ctl_sts_type                sts,
   input  wire logic                  rsp_tready,
   output logic                       rsp_tvalid,
   output logic [RSP_DATA_W-1:0]      rsp_tdata,
   output logic [RSP_USER_W-1:0]      rsp_tuser
);

   // item registers
   logic [2:0]        op_ff;
   logic [CH_W-1:0]   ch_ff;
   logic [NOTE_W-1:0] d1_ff;
   logic [NOTE_W-1:0] d2_ff;
   logic              sched_ff;

   // config registers
   logic [7:0]        trans_ff;
   logic [NOTE_W-1:0] expr_ff;

   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [PROD_W-1:0] prod_ff;

   logic [HOLD_W-1:0] mem [MEM_DEPTH];
   logic [HOLD_W-1:0] mem_rd_ff;
   logic              mem_we;
   logic [MEM_AW-1:0] mem_waddr;
   logic [MEM_AW-1:0] mem_raddr;
   logic [HOLD_W-1:0] mem_wdata;

   logic [7:0] totals_ff [NUM_CHANNELS];
   logic [7:0] top_ff    [NUM_CHANNELS];
   logic [7:0] bot_ff    [NUM_CHANNELS];
   logic [7:0] totals_in [NUM_CHANNELS];
   logic [7:0] top_in    [NUM_CHANNELS];
   logic [7:0] bot_in    [NUM_CHANNELS];

   logic                  rsp_valid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic [RSP_USER_W-1:0] rsp_user_ff, rsp_user_in;

   logic              tracked;
   logic signed [8:0] note_sum;
   logic [NOTE_W-1:0] note;
   logic [MEM_AW-1:0] item_addr;
   logic [7:0]        cur_total;
   logic [7:0]        cur_top;
   logic [7:0]        cur_bot;
   logic              on_hit;
   logic              off_hit;
   logic              release_zero;
   logic              at_extreme;
   logic [HOLD_W-1:0] new_count;
   logic [NOTE_W-1:0] scan_note;
   logic              scan_hit;

   logic [NOTE_W-1:0] quot;
   logic [PROD_W-1:0] quot_x127;
   logic [PROD_W-1:0] rem;
   logic [NOTE_W-1:0] scaled;
   logic              suppress;

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         op_ff    <= req_tdata[2:0];
         ch_ff    <= req_tdata[6:3];
         d1_ff    <= req_tdata[13:7];
         d2_ff    <= req_tdata[20:14];
         sched_ff <= req_tuser[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         trans_ff <= 8'd0;
         expr_ff  <= 7'd127;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_TRANSPOSE: trans_ff <= csr_wdata;
            CSR_EXPR_MAX:  expr_ff  <= csr_wdata[NOTE_W-1:0];
            default: ;
         endcase
      end
   end

   // note transpose with clamping, drum channel passes through
   assign tracked  = {1'b0, ch_ff} < CNT_CH_W'(NUM_CHANNELS);
   assign note_sum = $signed({2'b00, d1_ff}) + $signed({trans_ff[7], trans_ff});

   always_comb begin
      if (ch_ff == DRUM_CHANNEL) begin
         note = d1_ff;
      end else if (note_sum < 0) begin
         note = '0;
      end else if (note_sum > $signed({2'b00, NOTE_TOP})) begin
         note = NOTE_TOP;
      end else begin
         note = note_sum[NOTE_W-1:0];
      end
   end

   assign item_addr = {ch_ff, note};
   assign cur_total = totals_ff[ch_ff];
   assign cur_top   = top_ff[ch_ff];
   assign cur_bot   = bot_ff[ch_ff];

   assign on_hit       = (op_ff == OP_NOTE_ON) && (d2_ff != '0);
   assign off_hit      = (op_ff == OP_NOTE_OFF) && (mem_rd_ff != '0);
   assign release_zero = off_hit && (mem_rd_ff == HOLD_W'(1));
   assign at_extreme   = ({1'b0, note} == cur_top) || ({1'b0, note} == cur_bot);
   assign new_count    = on_hit ? ((mem_rd_ff == HOLD_MAX) ? mem_rd_ff : mem_rd_ff + 1'b1)
                                : mem_rd_ff - 1'b1;

   assign scan_note = cnt_ff[NOTE_W-1:0] - 1'b1;
   assign scan_hit  = cmd.scan && (cnt_ff[NOTE_W:0] != '0) && (mem_rd_ff != '0);

   // hold-count memory
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = item_addr;
      mem_wdata = new_count;
      mem_raddr = item_addr;
      if (cmd.init_wr) begin
         mem_we    = 1'b1;
         mem_waddr = cnt_ff[MEM_AW-1:0];
         mem_wdata = '0;
      end else if (cmd.clr_wr) begin
         mem_we    = 1'b1;
         mem_waddr = {ch_ff, cnt_ff[NOTE_W-1:0]};
         mem_wdata = '0;
      end else if (cmd.update) begin
         mem_we = on_hit || off_hit;
      end
      if (cmd.scan) begin
         mem_raddr = {ch_ff, cnt_ff[NOTE_W-1:0]};
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (cmd.mem_read || cmd.scan) begin
         mem_rd_ff <= mem[mem_raddr];
      end
   end

   // sweep counter
   always_comb begin
      cnt_in = cnt_ff;
      if (cmd.cnt_clear) begin
         cnt_in = '0;
      end else if (cmd.cnt_inc) begin
         cnt_in = cnt_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   // per-channel summary
   always_comb begin
      totals_in = totals_ff;
      top_in    = top_ff;
      bot_in    = bot_ff;
      if (cmd.update && tracked) begin
         if (on_hit && (mem_rd_ff == '0)) begin
            totals_in[ch_ff] = cur_total + 1'b1;
            if (cur_bot[7] || ({1'b0, note} < cur_bot)) begin
               bot_in[ch_ff] = {1'b0, note};
            end
            if (cur_top[7] || ({1'b0, note} > cur_top)) begin
               top_in[ch_ff] = {1'b0, note};
            end
         end
         if (release_zero) begin
            if (cur_total != '0) begin
               totals_in[ch_ff] = cur_total - 1'b1;
            end
            if (at_extreme) begin
               top_in[ch_ff] = NOTE_NONE;
               bot_in[ch_ff] = NOTE_NONE;
            end
         end
      end
      if (cmd.clr_chan) begin
         totals_in[ch_ff] = '0;
         top_in[ch_ff]    = NOTE_NONE;
         bot_in[ch_ff]    = NOTE_NONE;
      end
      if (scan_hit) begin
         if (cur_bot[7]) begin
            bot_in[ch_ff] = {1'b0, scan_note};
         end
         top_in[ch_ff] = {1'b0, scan_note};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_CHANNELS; i++) begin
            totals_ff[i] <= '0;
            top_ff[i]    <= NOTE_NONE;
            bot_ff[i]    <= NOTE_NONE;
         end
      end else begin
         totals_ff <= totals_in;
         top_ff    <= top_in;
         bot_ff    <= bot_in;
      end
   end

   // expression scaling: product registered, then divide by 127
   always_ff @(posedge clock) begin
      prod_ff <= {{NOTE_W{1'b0}}, d2_ff} * {{NOTE_W{1'b0}}, expr_ff};
   end

   assign quot      = prod_ff[PROD_W-1:NOTE_W];
   assign quot_x127 = {quot, {NOTE_W{1'b0}}} - {{NOTE_W{1'b0}}, quot};
   assign rem       = prod_ff - quot_x127;
   assign scaled    = (rem >= PROD_W'(NOTE_TOP)) ? quot + 1'b1 : quot;

   assign suppress = sched_ff && ((d1_ff == CC_VOLUME) || (d1_ff == CC_PAN) ||
                                  (d1_ff == CC_REVERB) || (d1_ff == CC_CHORUS));

   // result beat
   always_comb begin
      logic [2:0]        f_cmd;
      logic [NOTE_W-1:0] f_first;
      logic [NOTE_W-1:0] f_second;
      logic [BEND_W-1:0] f_bend;
      logic              f_fwd;
      logic              f_act;
      logic              f_gate;
      logic [7:0]        f_total;
      logic [7:0]        f_top;
      logic [7:0]        f_bot;
      f_cmd    = op_ff;
      f_first  = '0;
      f_second = '0;
      f_bend   = '0;
      f_fwd    = 1'b1;
      f_act    = 1'b0;
      case (op_ff)
         OP_NOTE_ON: begin
            f_first  = note;
            f_second = d2_ff;
            f_act    = 1'b1;
         end
         OP_NOTE_OFF: begin
            f_first = note;
            f_act   = 1'b1;
         end
         OP_CONTROL: begin
            f_first  = d1_ff;
            f_second = (d1_ff == CC_EXPRESSION) ? scaled : d2_ff;
            f_act    = 1'b1;
            f_fwd    = !suppress;
         end
         OP_PROGRAM: begin
            f_first = d1_ff;
            f_act   = 1'b1;
         end
         OP_BEND: begin
            f_first  = d1_ff;
            f_second = d2_ff;
            f_bend   = {d2_ff, d1_ff};
            f_act    = 1'b1;
         end
         OP_NOTES_OFF, OP_SOUND_OFF: ;
         default: begin
            f_cmd = OP_NOTE_ON;
            f_fwd = 1'b0;
         end
      endcase
      if (tracked) begin
         f_total = cur_total;
         f_gate  = cur_total != '0;
         f_top   = cur_top;
         f_bot   = cur_bot;
      end else begin
         f_act   = 1'b0;
         f_total = '0;
         f_gate  = 1'b0;
         f_top   = NOTE_NONE;
         f_bot   = NOTE_NONE;
      end
      rsp_data_in = {4'd0, f_bot, f_top, f_total, f_gate, f_bend,
                     f_second, f_first, ch_ff, f_cmd};
      rsp_user_in = {f_act, f_fwd};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_data_ff <= rsp_data_in;
         rsp_user_ff <= rsp_user_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   always_comb begin
      sts              = '0;
      sts.note_op      = tracked && ((op_ff == OP_NOTE_ON) || (op_ff == OP_NOTE_OFF));
      sts.clear_op     = tracked && ((op_ff == OP_NOTES_OFF) || (op_ff == OP_SOUND_OFF));
      sts.need_scan    = tracked && release_zero && at_extreme;
      sts.cnt_init_end = cnt_ff == CNT_W'(MEM_DEPTH - 1);
      sts.cnt_row_end  = cnt_ff[NOTE_W-1:0] == NOTE_TOP;
      sts.cnt_scan_end = cnt_ff[NOTE_W:0] == (NOTE_W+1)'(NUM_NOTES);
      sts.rsp_free     = !rsp_valid_ff || rsp_tready;
   end

endmodule
`default_nettype wire

// ===== rtl/core/midi_channel_note_tracker_core.sv =====
// midi channel note tracker: one result beat per event beat
// a release at an extremum rescans the channel's 128 hold counts, and all-notes/sound-off
// zeroes that channel's 128 hold counts
// throughput: one event at a time; the next beat is taken once the result is loaded
// reset: synchronous; a sweep then zeroes all 2048 entries of the hold-count memory
// before the first event beat is taken (config writes are accepted meanwhile)
`default_nettype none
module midi_channel_note_tracker_core import mcnt_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // operation[2:0], channel[6:3], data_one[13:7], data_two[20:14], zero pad
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   // from_schedule[0]
   input  wire logic [REQ_USER_W-1:0] req_tuser,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // command[2:0], out_channel[6:3], out_first[13:7], out_second[20:14],
   // bend_amount[34:21], gate_active[35], active_notes[43:36],
   // highest_held[51:44], lowest_held[59:52], zero pad
   output logic [RSP_DATA_W-1:0]      rsp_tdata,
   // forward_valid[0], activity_mark[1]
   output logic [RSP_USER_W-1:0]      rsp_tuser,
   input  wire logic                  csr_we,
   input  wire logic [CSR_ADDR_W-1:0] csr_addr,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   ctl_cmd_type cmd;
   ctl_sts_type sts;

   mcnt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   mcnt_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .cmd        (cmd),
      .sts        (sts),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule
`default_nettype wire

// ===== rtl/core/mcnt_checker.sv =====
// mcnt_checker: port-level assertions on the result channel of the tracker
// depends on mcnt_pkg; bound to midi_channel_note_tracker_core
`default_nettype none
module mcnt_checker import mcnt_pkg::*; (
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  rsp_tvalid,
   input wire logic                  rsp_tready,
   input wire logic [RSP_DATA_W-1:0] rsp_tdata,
   input wire logic [RSP_USER_W-1:0] rsp_tuser
);

   logic [2:0]  r_cmd;
   logic [13:0] r_bend;
   logic        r_gate;
   logic [7:0]  r_total;
   logic [7:0]  r_top;
   logic [7:0]  r_bot;

   assign r_cmd   = rsp_tdata[2:0];
   assign r_bend  = rsp_tdata[34:21];
   assign r_gate  = rsp_tdata[35];
   assign r_total = rsp_tdata[43:36];
   assign r_top   = rsp_tdata[51:44];
   assign r_bot   = rsp_tdata[59:52];

   // stalled beat holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result beat changed while stalled");

   a_gate: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (r_gate == (r_total != 8'd0)))
      else $error("gate_active disagrees with active_notes");

   a_none: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (((r_total == 8'd0) == (r_top == NOTE_NONE)) &&
                      ((r_total == 8'd0) == (r_bot == NOTE_NONE))))
      else $error("held extremes disagree with active_notes");

   a_order: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (r_total != 8'd0) |-> (r_bot <= r_top) && (r_total <= 8'd128))
      else $error("lowest held note above highest");

   a_bend: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (r_bend != 14'd0) |-> (r_cmd == OP_BEND))
      else $error("bend_amount set on a non-bend command");

endmodule

bind midi_channel_note_tracker_core mcnt_checker u_checker (.*);
`default_nettype wire

// ===== tb/note_tracker_checker.sv =====
`timescale 1ns / 100ps
// note_tracker_checker: watches the event, result and register ports of the note tracker,
// keeps its own copy of the hold counts and settings, and compares every result beat
// depends on mcnt_pkg for widths, operation codes and register indexes
module note_tracker_checker import mcnt_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   input  wire logic                  req_tready,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   input  wire logic [REQ_USER_W-1:0] req_tuser,
   input  wire logic                  rsp_tvalid,
   input  wire logic                  rsp_tready,
   input  wire logic [RSP_DATA_W-1:0] rsp_tdata,
   input  wire logic [RSP_USER_W-1:0] rsp_tuser,
   input  wire logic                  csr_we,
   input  wire logic [CSR_ADDR_W-1:0] csr_addr,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata,
   output int                         fail_count,
   output int                         pending_count
);

   typedef struct packed {
      logic [2:0]        command;
      logic [CH_W-1:0]   chan;
      logic [NOTE_W-1:0] first;
      logic [NOTE_W-1:0] second;
      logic [BEND_W-1:0] bend;
      logic              forward;
      logic              activity;
      logic              gate;
      logic [7:0]        active;
      logic [7:0]        highest;
      logic [7:0]        lowest;
   } forward_cmd_type;

   logic [HOLD_W-1:0] hold_count [NUM_CHANNELS][NUM_NOTES];
   int                held_total [NUM_CHANNELS];
   int                top_note [NUM_CHANNELS];
   int                bottom_note [NUM_CHANNELS];
   int                transpose;
   int                expr_ceiling;
   forward_cmd_type   forward_q[$];
   int                errors = 0;

   assign fail_count = errors;

   function automatic logic [NOTE_W-1:0] shifted_note(input logic [CH_W-1:0] ch,
                                                      input logic [NOTE_W-1:0] note);
      int t;
      if (ch == DRUM_CHANNEL) return note;
      t = int'(note) + transpose;
      if (t < 0) t = 0;
      if (t > 127) t = 127;
      return t[NOTE_W-1:0];
   endfunction

   function automatic void rescan_extremes(input int c);
      top_note[c] = -1;
      bottom_note[c] = -1;
      for (int n = 0; n < NUM_NOTES; n++) begin
         if (hold_count[c][n] != 0) begin
            if (bottom_note[c] < 0) bottom_note[c] = n;
            top_note[c] = n;
         end
      end
   endfunction

   function automatic void clear_notes(input int c);
      for (int n = 0; n < NUM_NOTES; n++) hold_count[c][n] = '0;
      held_total[c] = 0;
      top_note[c] = -1;
      bottom_note[c] = -1;
   endfunction

   // applies one event to the tracked state and returns the command to forward
   function automatic forward_cmd_type track_event(input logic [2:0] op,
                                                   input logic [CH_W-1:0] ch,
                                                   input logic [NOTE_W-1:0] d1,
                                                   input logic [NOTE_W-1:0] d2,
                                                   input logic sched);
      forward_cmd_type r;
      int           c;
      int           nt;
      logic [NOTE_W-1:0] note;
      c = ch;
      r = '0;
      r.command = op;
      r.chan = ch;
      r.forward = 1'b1;
      case (op)
         OP_NOTE_ON, OP_NOTE_OFF: begin
            note = shifted_note(ch, d1);
            nt = note;
            r.first = note;
            r.second = (op == OP_NOTE_ON) ? d2 : '0;
            r.activity = 1'b1;
            if (op == OP_NOTE_ON && d2 != 0) begin
               if (hold_count[c][nt] == 0) begin
                  held_total[c]++;
                  if (bottom_note[c] < 0 || nt < bottom_note[c]) bottom_note[c] = nt;
                  if (top_note[c] < 0 || nt > top_note[c]) top_note[c] = nt;
               end
               if (hold_count[c][nt] < HOLD_MAX) hold_count[c][nt]++;
            end else if (op == OP_NOTE_OFF && hold_count[c][nt] > 0) begin
               hold_count[c][nt]--;
               if (hold_count[c][nt] == 0) begin
                  if (held_total[c] > 0) held_total[c]--;
                  if (nt == top_note[c] || nt == bottom_note[c]) rescan_extremes(c);
               end
            end
         end
         OP_CONTROL: begin
            r.first = d1;
            r.second = (d1 == CC_EXPRESSION) ? NOTE_W'((int'(d2) * expr_ceiling) / 127) : d2;
            r.activity = 1'b1;
            if (sched && (d1 inside {CC_VOLUME, CC_PAN, CC_REVERB, CC_CHORUS}))
               r.forward = 1'b0;
         end
         OP_PROGRAM: begin
            r.first = d1;
            r.activity = 1'b1;
         end
         OP_BEND: begin
            r.first = d1;
            r.second = d2;
            r.bend = {d2, d1};
            r.activity = 1'b1;
         end
         OP_NOTES_OFF, OP_SOUND_OFF: begin
            clear_notes(c);
         end
         default: begin
            r.command = OP_NOTE_ON;
            r.forward = 1'b0;
         end
      endcase
      r.gate = (held_total[c] > 0);
      r.active = held_total[c][7:0];
      r.highest = top_note[c][7:0];
      r.lowest = bottom_note[c][7:0];
      return r;
   endfunction

   function automatic void check_field(input string name, input int expv, input int gotv);
      if (expv != gotv) begin
         $error("%s: expected %0d, actual %0d", name, expv, gotv);
         errors++;
      end
   endfunction

   function automatic void compare_result(input forward_cmd_type exp_r);
      check_field("command", exp_r.command, rsp_tdata[2:0]);
      check_field("out_channel", exp_r.chan, rsp_tdata[6:3]);
      check_field("out_first", exp_r.first, rsp_tdata[13:7]);
      check_field("out_second", exp_r.second, rsp_tdata[20:14]);
      check_field("bend_amount", exp_r.bend, rsp_tdata[34:21]);
      check_field("forward_valid", exp_r.forward, rsp_tuser[0]);
      check_field("activity_mark", exp_r.activity, rsp_tuser[1]);
      check_field("gate_active", exp_r.gate, rsp_tdata[35]);
      check_field("active_notes", exp_r.active, rsp_tdata[43:36]);
      check_field("highest_held", int'($signed(exp_r.highest)),
                  int'($signed(rsp_tdata[51:44])));
      check_field("lowest_held", int'($signed(exp_r.lowest)),
                  int'($signed(rsp_tdata[59:52])));
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < NUM_CHANNELS; c++) clear_notes(c);
         transpose = 0;
         expr_ceiling = 127;
         forward_q.delete();
      end else begin
         if (csr_we) begin
            case (csr_addr)
               CSR_TRANSPOSE: transpose = int'($signed(csr_wdata));
               CSR_EXPR_MAX:  expr_ceiling = csr_wdata[6:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready)
            forward_q.push_back(track_event(req_tdata[2:0], req_tdata[6:3], req_tdata[13:7],
                                            req_tdata[20:14], req_tuser[0]));
         if (rsp_tvalid && rsp_tready) begin
            if (forward_q.size() == 0) begin
               $error("result beat with no event waiting");
               errors++;
            end else begin
               compare_result(forward_q.pop_front());
            end
         end
      end
      pending_count <= forward_q.size();
   end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// tb_top: drives events and register writes into midi_channel_note_tracker_core under random
// flow control and gives the verdict; depends on mcnt_pkg and note_tracker_checker
module tb_top;
   import mcnt_pkg::*;

   localparam int CYCLE_LIMIT = 1_000_000;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [REQ_USER_W-1:0] req_tuser = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [RSP_USER_W-1:0] rsp_tuser;
   logic                  csr_we = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;
   int                    fail_count;
   int                    pending_count;
   int                    cycle_count = 0;
   bit                    steady_flow = 1'b0;
   int                    note_base;
   int                    chan_pick;

   midi_channel_note_tracker_core uut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser),
      .csr_we(csr_we), .csr_addr(csr_addr), .csr_wdata(csr_wdata)
   );

   note_tracker_checker checker_i (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser),
      .csr_we(csr_we), .csr_addr(csr_addr), .csr_wdata(csr_wdata),
      .fail_count(fail_count), .pending_count(pending_count)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("midi_channel_note_tracker_core regression: fail");
         $finish;
      end
   end

   // result side back-pressure
   initial begin
      int stall;
      while (reset) @(posedge clock);
      forever begin
         stall = steady_flow ? 0 : $urandom_range(0, 6);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   task automatic send_event(input logic [2:0] op, input logic [CH_W-1:0] ch,
                             input logic [NOTE_W-1:0] d1, input logic [NOTE_W-1:0] d2,
                             input logic sched);
      int gap;
      gap = steady_flow ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {3'b000, d2, d1, ch, op};
      req_tuser <= sched;
      do @(posedge clock); while (!req_tready);
      if ($urandom_range(0, 59) == 0) steady_flow = !steady_flow;
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   task automatic write_settings(input logic [7:0] shift, input logic [6:0] ceiling);
      csr_we <= 1'b1;
      csr_addr <= CSR_TRANSPOSE;
      csr_wdata <= shift;
      @(posedge clock);
      csr_addr <= CSR_EXPR_MAX;
      csr_wdata <= {1'b0, ceiling};
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   function automatic logic [CH_W-1:0] pick_channel();
      int r;
      r = $urandom_range(0, 9);
      if (r < 3) return CH_W'(chan_pick);
      if (r < 5) return DRUM_CHANNEL;
      if (r < 7) return '0;
      return CH_W'($urandom_range(0, 15));
   endfunction

   function automatic logic [NOTE_W-1:0] pick_note();
      return NOTE_W'((note_base + $urandom_range(0, 11)) % 128);
   endfunction

   task automatic random_event();
      int               kind;
      logic [NOTE_W-1:0] cc;
      kind = $urandom_range(0, 99);
      if (kind < 40) begin
         send_event(OP_NOTE_ON, pick_channel(), pick_note(),
                    ($urandom_range(0, 19) == 0) ? 7'd0 : NOTE_W'($urandom_range(1, 127)),
                    1'($urandom_range(0, 1)));
      end else if (kind < 70) begin
         send_event(OP_NOTE_OFF, pick_channel(), pick_note(), NOTE_W'($urandom_range(0, 127)),
                    1'($urandom_range(0, 1)));
      end else if (kind < 80) begin
         case ($urandom_range(0, 5))
            0: cc = CC_VOLUME;
            1: cc = CC_PAN;
            2: cc = CC_EXPRESSION;
            3: cc = CC_REVERB;
            4: cc = CC_CHORUS;
            default: cc = NOTE_W'($urandom_range(0, 127));
         endcase
         send_event(OP_CONTROL, pick_channel(), cc, NOTE_W'($urandom_range(0, 127)),
                    1'($urandom_range(0, 1)));
      end else if (kind < 86) begin
         send_event(OP_BEND, pick_channel(), NOTE_W'($urandom_range(0, 127)),
                    NOTE_W'($urandom_range(0, 127)), 1'($urandom_range(0, 1)));
      end else if (kind < 91) begin
         send_event(OP_PROGRAM, pick_channel(), NOTE_W'($urandom_range(0, 127)),
                    NOTE_W'($urandom_range(0, 127)), 1'($urandom_range(0, 1)));
      end else if (kind < 95) begin
         send_event(($urandom_range(0, 1) != 0) ? OP_NOTES_OFF : OP_SOUND_OFF, pick_channel(),
                    NOTE_W'($urandom_range(0, 127)), NOTE_W'($urandom_range(0, 127)),
                    1'($urandom_range(0, 1)));
      end else begin
         send_event(3'($urandom_range(0, 7)), CH_W'($urandom_range(0, 15)),
                    NOTE_W'($urandom_range(0, 127)), NOTE_W'($urandom_range(0, 127)),
                    1'($urandom_range(0, 1)));
      end
   endtask

   task automatic random_phase(input int count);
      for (int i = 0; i < count; i++) begin
         if (i % 40 == 0) begin
            note_base = ($urandom_range(0, 3) == 0) ? (($urandom_range(0, 1) != 0) ? 116 : 0)
                                                    : $urandom_range(0, 116);
            chan_pick = $urandom_range(0, 15);
         end
         random_event();
      end
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed: extremes, every operation, corner cases
      write_settings(8'd0, 7'd127);
      send_event(OP_NOTE_ON, 4'd0, 7'd0, 7'd127, 1'b1);
      send_event(OP_NOTE_ON, 4'd0, 7'd127, 7'd1, 1'b0);
      send_event(OP_NOTE_ON, 4'd0, 7'd0, 7'd64, 1'b0);
      send_event(OP_NOTE_ON, 4'd0, 7'd64, 7'd0, 1'b0);
      send_event(OP_NOTE_OFF, 4'd0, 7'd64, 7'd127, 1'b0);
      send_event(OP_NOTE_ON, 4'd0, 7'd64, 7'd100, 1'b0);
      send_event(OP_NOTE_OFF, 4'd0, 7'd0, 7'd0, 1'b0);
      send_event(OP_NOTE_OFF, 4'd0, 7'd0, 7'd0, 1'b0);
      send_event(OP_NOTE_OFF, 4'd0, 7'd127, 7'd0, 1'b0);
      send_event(OP_NOTE_ON, DRUM_CHANNEL, 7'd127, 7'd90, 1'b0);
      send_event(OP_CONTROL, 4'd15, CC_EXPRESSION, 7'd127, 1'b0);
      send_event(OP_CONTROL, 4'd15, CC_EXPRESSION, 7'd0, 1'b1);
      send_event(OP_CONTROL, 4'd1, CC_VOLUME, 7'd100, 1'b1);
      send_event(OP_CONTROL, 4'd1, CC_PAN, 7'd64, 1'b0);
      send_event(OP_CONTROL, 4'd1, CC_REVERB, 7'd127, 1'b1);
      send_event(OP_CONTROL, 4'd1, CC_CHORUS, 7'd1, 1'b1);
      send_event(OP_PROGRAM, 4'd2, 7'd127, 7'd127, 1'b0);
      send_event(OP_BEND, 4'd3, 7'd127, 7'd127, 1'b0);
      send_event(OP_BEND, 4'd3, 7'd0, 7'd0, 1'b1);
      send_event(OP_NOTES_OFF, 4'd0, 7'd5, 7'd5, 1'b0);
      send_event(OP_SOUND_OFF, DRUM_CHANNEL, 7'd0, 7'd0, 1'b0);
      send_event(3'd7, 4'd3, 7'd127, 7'd127, 1'b1);
      drain_results();

      write_settings(8'd127, 7'd0);
      random_phase(230);
      // hold count saturation on one note, then a clear
      for (int i = 0; i < 258; i++)
         send_event(OP_NOTE_ON, 4'd2, 7'd60, NOTE_W'($urandom_range(1, 127)), 1'b0);
      send_event(OP_NOTE_OFF, 4'd2, 7'd60, 7'd0, 1'b0);
      send_event(OP_NOTE_OFF, 4'd2, 7'd60, 7'd0, 1'b0);
      send_event(OP_NOTES_OFF, 4'd2, 7'd0, 7'd0, 1'b0);
      drain_results();

      write_settings(8'h80, 7'd127);
      random_phase(230);
      drain_results();

      write_settings(8'h81, 7'd64);
      random_phase(230);
      drain_results();

      write_settings(8'($signed($urandom_range(0, 48)) - 24), 7'($urandom_range(0, 127)));
      random_phase(230);
      drain_results();

      write_settings(8'($urandom_range(0, 255)), 7'($urandom_range(0, 127)));
      random_phase(230);
      drain_results();

      repeat (140) @(posedge clock);
      if (fail_count == 0 && pending_count == 0)
         $display("midi_channel_note_tracker_core regression: pass");
      else
         $display("midi_channel_note_tracker_core regression: fail");
      $finish;
   end

endmodule
